// ----- rtl/ffha_pkg.sv -----
// shared types and constants of the first-fit heap allocator
package ffha_pkg;

    // fixed field widths
    localparam int ADDR_W  = 32;
    localparam int SIZE_W  = 23;
    // a block's byte charge: size plus header, plus gap when appended, header at most 64
    localparam int DELTA_W = 24;

    // spacing between the end of one block and the header of the next
    localparam logic [ADDR_W-1:0]  GAP_BYTES   = 32'd4;
    localparam logic [DELTA_W-1:0] GAP_BYTES_D = 24'd4;

    // request kinds
    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    // configuration register indexes
    localparam logic REG_HEAP_START = 1'b0;
    localparam logic REG_HEAP_STOP  = 1'b1;

    typedef enum logic [1:0] {
        ST_OK           = 2'd0,
        ST_ZERO_SIZE    = 2'd1,
        ST_NO_MEMORY    = 2'd2,
        ST_UNKNOWN_ADDR = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_END,
        S_DONE
    } ctrl_state_t;

    typedef struct packed {
        logic              action;
        logic [SIZE_W-1:0] request_bytes;
        logic [ADDR_W-1:0] block_address;
    } in_item_t;

    typedef struct packed {
        logic [ADDR_W-1:0] payload_address;
        status_t           status;
        logic [ADDR_W-1:0] bytes_in_use;
    } out_item_t;

    // one entry of the block table
    typedef struct packed {
        logic              used;
        logic [SIZE_W-1:0] size;
    } blk_entry_t;

    // configuration as seen by the sequencer
    typedef struct packed {
        logic              clear;
        logic [ADDR_W-1:0] new_start;
        logic [ADDR_W-1:0] heap_start;
        logic [ADDR_W-1:0] heap_stop;
    } cfg_t;

endpackage

// ----- rtl/ffha_block_mem.sv -----
// block table memory: one write port, one registered read port
module ffha_block_mem #(
    parameter int DEPTH = 256
) (
    input  logic                                        clk,
    input  logic                                        wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  ffha_pkg::blk_entry_t                        wr_data,
    input  logic                                        rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output ffha_pkg::blk_entry_t                        rd_data
);
    import ffha_pkg::*;

    blk_entry_t mem [DEPTH];

    // write and read, read data registered
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ----- rtl/ffha_ctrl.sv -----
// request sequencer: walks the block table, appends, keeps the accounting
module ffha_ctrl #(
    parameter int MAX_BLOCKS   = 256,
    parameter int HEADER_BYTES = 8
) (
    input  logic                                                  clk,
    input  logic                                                  rst_n,
    input  ffha_pkg::cfg_t                                        cfg,
    input  logic                                                  in_valid,
    output logic                                                  in_stall,
    input  ffha_pkg::in_item_t                                    in_data,
    output logic                                                  out_valid,
    input  logic                                                  out_stall,
    output ffha_pkg::out_item_t                                   out_data,
    output logic                                                  wr_en,
    output logic [((MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1)-1:0] wr_addr,
    output ffha_pkg::blk_entry_t                                  wr_data,
    output logic                                                  rd_en,
    output logic [((MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1)-1:0] rd_addr,
    input  ffha_pkg::blk_entry_t                                  rd_data
);
    import ffha_pkg::*;

    localparam int IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
    localparam logic [ADDR_W-1:0]  HDR_A = ADDR_W'(HEADER_BYTES);
    localparam logic [ADDR_W:0]    HDR_W = (ADDR_W + 1)'(HEADER_BYTES);
    localparam logic [DELTA_W-1:0] HDR_D = DELTA_W'(HEADER_BYTES);
    localparam logic [CNT_W-1:0]   FULL  = CNT_W'(MAX_BLOCKS);

    ctrl_state_t        state_reg,   state_next;
    in_item_t           item_reg,    item_next;
    logic [IDX_W-1:0]   idx_reg,     idx_next;
    logic [ADDR_W-1:0]  addr_reg,    addr_next;
    logic [CNT_W-1:0]   count_reg,   count_next;
    logic [ADDR_W-1:0]  append_reg,  append_next;
    logic [ADDR_W-1:0]  used_reg,    used_next;
    logic [ADDR_W-1:0]  payload_reg, payload_next;
    status_t            status_reg,  status_next;
    logic [DELTA_W-1:0] delta_reg,   delta_next;
    logic               dec_reg,     dec_next;
    logic               apply_reg,   apply_next;
    logic               ovalid_reg,  ovalid_next;
    out_item_t          out_reg,     out_next;

    logic [ADDR_W-1:0] pay;
    logic              hit;
    logic [CNT_W-1:0]  next_cnt;
    logic [ADDR_W:0]   end_addr;
    logic [ADDR_W:0]   add_sum;
    logic [ADDR_W-1:0] used_new;
    logic              is_alloc;

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            append_reg <= '0;
            used_reg   <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            append_reg <= append_next;
            used_reg   <= used_next;
            ovalid_reg <= ovalid_next;
        end
    end

    // working and result registers
    always_ff @(posedge clk)
    begin
        item_reg    <= item_next;
        idx_reg     <= idx_next;
        addr_reg    <= addr_next;
        payload_reg <= payload_next;
        status_reg  <= status_next;
        delta_reg   <= delta_next;
        dec_reg     <= dec_next;
        apply_reg   <= apply_next;
        out_reg     <= out_next;
    end

    // next state and outputs
    always_comb
    begin
        state_next   = state_reg;
        item_next    = item_reg;
        idx_next     = idx_reg;
        addr_next    = addr_reg;
        count_next   = count_reg;
        append_next  = append_reg;
        used_next    = used_reg;
        payload_next = payload_reg;
        status_next  = status_reg;
        delta_next   = delta_reg;
        dec_next     = dec_reg;
        apply_next   = apply_reg;
        out_next     = out_reg;
        ovalid_next  = ovalid_reg;

        in_stall = (state_reg != S_IDLE);
        rd_en    = 1'b0;
        rd_addr  = '0;
        wr_en    = 1'b0;
        wr_addr  = idx_reg;
        wr_data  = '0;

        is_alloc = (item_reg.action == ACT_ALLOC);
        pay      = addr_reg + HDR_A;
        hit      = is_alloc ? (!rd_data.used && (rd_data.size >= item_reg.request_bytes))
                            : (pay == item_reg.block_address);
        next_cnt = CNT_W'(idx_reg) + CNT_W'(1);
        end_addr = {1'b0, append_reg} + (ADDR_W + 1)'(item_reg.request_bytes) + HDR_W;

        // saturating update of the bytes-in-use count
        add_sum = {1'b0, used_reg} + (ADDR_W + 1)'(delta_reg);
        if (!apply_reg)
        begin
            used_new = used_reg;
        end
        else if (dec_reg)
        begin
            used_new = (used_reg > ADDR_W'(delta_reg)) ? (used_reg - ADDR_W'(delta_reg)) : '0;
        end
        else
        begin
            used_new = add_sum[ADDR_W] ? '1 : add_sum[ADDR_W-1:0];
        end

        // output beat taken
        if (ovalid_reg && !out_stall)
        begin
            ovalid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    item_next    = in_data;
                    idx_next     = '0;
                    addr_next    = cfg.heap_start;
                    payload_next = '0;
                    apply_next   = 1'b0;
                    dec_next     = 1'b0;
                    if (in_data.action == ACT_ALLOC && in_data.request_bytes == '0)
                    begin
                        status_next = ST_ZERO_SIZE;
                        state_next  = S_DONE;
                    end
                    else if (count_reg == '0)
                    begin
                        state_next = S_END;
                    end
                    else
                    begin
                        rd_en      = 1'b1;
                        rd_addr    = '0;
                        state_next = S_WALK;
                    end
                end
            end

            S_WALK:
            begin
                // entry idx_reg is on the read port
                if (hit)
                begin
                    wr_en        = 1'b1;
                    wr_addr      = idx_reg;
                    wr_data.used = is_alloc;
                    wr_data.size = rd_data.size;
                    status_next  = ST_OK;
                    payload_next = is_alloc ? pay : '0;
                    delta_next   = is_alloc ? (DELTA_W'(item_reg.request_bytes) + HDR_D)
                                            : (DELTA_W'(rd_data.size) + HDR_D);
                    dec_next     = !is_alloc;
                    apply_next   = 1'b1;
                    state_next   = S_DONE;
                end
                else
                begin
                    addr_next = addr_reg + ADDR_W'(rd_data.size) + HDR_A + GAP_BYTES;
                    idx_next  = next_cnt[IDX_W-1:0];
                    if (next_cnt == count_reg)
                    begin
                        state_next = S_END;
                    end
                    else
                    begin
                        rd_en   = 1'b1;
                        rd_addr = next_cnt[IDX_W-1:0];
                    end
                end
            end

            S_END:
            begin
                // no fitting block, or no matching payload
                state_next = S_DONE;
                if (!is_alloc)
                begin
                    status_next = ST_UNKNOWN_ADDR;
                end
                else if (count_reg >= FULL || end_addr >= {1'b0, cfg.heap_stop})
                begin
                    status_next = ST_NO_MEMORY;
                end
                else
                begin
                    wr_en        = 1'b1;
                    wr_addr      = count_reg[IDX_W-1:0];
                    wr_data.used = 1'b1;
                    wr_data.size = item_reg.request_bytes;
                    count_next   = count_reg + CNT_W'(1);
                    append_next  = end_addr[ADDR_W-1:0] + GAP_BYTES;
                    payload_next = append_reg + HDR_A;
                    status_next  = ST_OK;
                    delta_next   = DELTA_W'(item_reg.request_bytes) + HDR_D + GAP_BYTES_D;
                    dec_next     = 1'b0;
                    apply_next   = 1'b1;
                end
            end

            S_DONE:
            begin
                // load the output register once it is free
                if (!ovalid_reg || !out_stall)
                begin
                    out_next.payload_address = payload_reg;
                    out_next.status          = status_reg;
                    out_next.bytes_in_use    = used_new;
                    ovalid_next              = 1'b1;
                    used_next                = used_new;
                    state_next               = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // moving heap_start empties the table
        if (cfg.clear)
        begin
            count_next  = '0;
            append_next = cfg.new_start;
            used_next   = '0;
        end
    end

    assign out_valid = ovalid_reg;
    assign out_data  = out_reg;

endmodule

// ----- rtl/first_fit_heap_allocator.sv -----
// First-fit heap allocator: one result beat for every request beat.
// Steps: a zero-size request goes from S_IDLE straight to S_DONE; any other
// request walks the table in S_WALK (skipped if empty), one entry per cycle
// through the block memory port, to S_DONE on a hit, else through S_END.
// Flow: one request at a time; the next is taken once the result is
// registered, while that result may still wait on out_stall.
// Reset: table empty, heap_start 0, heap_stop 4063232; table contents undefined.
module first_fit_heap_allocator #(
    parameter int MAX_BLOCKS   = 256,
    parameter int HEADER_BYTES = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_write,
    input  logic                cfg_index,
    input  logic [31:0]         cfg_data,
    input  logic                in_valid,
    output logic                in_stall,
    input  ffha_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output ffha_pkg::out_item_t out_data
);
    import ffha_pkg::*;

    localparam int IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;

    logic [ADDR_W-1:0] heap_start_reg;
    logic [ADDR_W-1:0] heap_stop_reg;
    cfg_t              cfg;

    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    blk_entry_t       wr_data;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    blk_entry_t       rd_data;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            heap_start_reg <= '0;
            heap_stop_reg  <= 32'd4063232;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_HEAP_START: heap_start_reg <= cfg_data;
                REG_HEAP_STOP:  heap_stop_reg  <= cfg_data;
                default:        heap_stop_reg  <= heap_stop_reg;
            endcase
        end
    end

    assign cfg.clear      = cfg_write && (cfg_index == REG_HEAP_START);
    assign cfg.new_start  = cfg_data;
    assign cfg.heap_start = heap_start_reg;
    assign cfg.heap_stop  = heap_stop_reg;

    ffha_ctrl #(
        .MAX_BLOCKS   (MAX_BLOCKS),
        .HEADER_BYTES (HEADER_BYTES)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data)
    );

    ffha_block_mem #(
        .DEPTH (MAX_BLOCKS)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // a request beat is never followed at once by another
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("request beat taken while a request is in progress");

    // failed requests grant no address
    a_no_grant_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status != ST_OK |-> out_data.payload_address == '0)
        else $error("payload address given with a failing status");

    // a request beat is not answered at once by a fresh result beat
    a_result_needs_request: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> !(out_valid && !$past(out_valid && out_stall)
                                    && !$past(out_valid)))
        else $error("result beat appeared in the cycle after a request beat");

endmodule
